/* hw/rtl/mtrr_range_memory_type_resolver_macros.svh */
// ----------------------------------------------------------------------------
// MTRR range resolver assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MTRR_RANGE_MEMORY_TYPE_RESOLVER_MACROS_SVH
`define MTRR_RANGE_MEMORY_TYPE_RESOLVER_MACROS_SVH

`ifndef SYNTHESIS
`define MTRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define MTRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MTRR_ASSERT(lbl, prop, msg)
`define MTRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/mtrr_pkg.sv */
// ----------------------------------------------------------------------------
// MTRR range resolver package
// Table sizes, field widths, memory type and status codes, entry layout.
// ----------------------------------------------------------------------------
package mtrr_pkg;

  localparam int unsigned MaxRanges = 16;
  localparam int unsigned CntW      = $clog2(MaxRanges + 1);
  localparam int unsigned IdxW      = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;

  // Addresses are kept as 4 KB frame numbers (address bits 51:12).
  localparam int unsigned FrameW    = 40;
  localparam int unsigned FrameLsb  = 12;
  localparam int unsigned PageW     = 18;
  localparam int unsigned PageSubW  = 21 - FrameLsb;
  localparam int unsigned TypeW     = 8;
  localparam int unsigned ValidBit  = 11;

  localparam int unsigned InDataW   = 152;
  localparam int unsigned OutDataW  = 16;

  localparam logic [TypeW-1:0] TypeUc = 8'd0;
  localparam logic [TypeW-1:0] TypeWb = 8'd6;

  typedef enum logic [2:0] {
    StStored   = 3'd0,
    StWbSkip   = 3'd1,
    StDisabled = 3'd2,
    StFull     = 3'd3,
    StQuery    = 3'd4
  } status_e;

  typedef struct packed {
    logic [FrameW-1:0] start_frame;
    logic [FrameW-1:0] last_frame;
    logic [TypeW-1:0]  kind;
  } range_entry_t;

endpackage

/* hw/rtl/mtrr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mtrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/mtrr_range_memory_type_resolver.sv */
// ----------------------------------------------------------------------------
// MTRR variable-range memory type resolver
// Stores variable-range MTRR pairs and classifies 2 MB pages against them.
// ----------------------------------------------------------------------------
//   Channel  Direction  Contents
//   s_axis   in         tuser: kind; tdata: base_word, mask_word, page_number
//   m_axis   out        tdata: status, memory_type
//
// Stored loads pass through the check and store states to the result; skipped loads
// leave the check state straight for the result. Page 0 skips the table scan; other
// queries read and compare one stored range per cycle until all are scanned, ending
// early on an uncacheable hit. One item is in work at a time. Reset clears the range
// count and all registers; the table needs no clearing pass. A stalled m_axis
// holds the result in the output register and the block stays busy behind it.
// ----------------------------------------------------------------------------
`include "mtrr_range_memory_type_resolver_macros.svh"

module mtrr_range_memory_type_resolver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [63:0] base_word, [127:64] mask_word, [145:128] page_number, rest zero
  input  logic [mtrr_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [10:3] memory_type, rest zero
  output logic [mtrr_pkg::OutDataW-1:0] m_axis_tdata
);
  import mtrr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_CHECK,
    ST_LOAD_STORE,
    ST_QUERY,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [FrameW-1:0] base_frame_q;
  logic [FrameW-1:0] mask_frame_q;
  logic              mask_valid_q;
  logic [TypeW-1:0]  type_q;
  logic [PageW-1:0]  page_q;
  logic [FrameW-1:0] span_q;
  logic [CntW-1:0]   issue_q;
  logic              pend_q;
  logic [CntW-1:0]   range_count_q;
  logic [TypeW-1:0]  res_type_q;
  status_e           res_status_q;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [TypeW-1:0]  out_type_q;

  logic [FrameW:0]   sum;
  logic [FrameW-1:0] last_frame;
  logic [FrameW-1:0] first_pg;
  logic [FrameW-1:0] final_pg;
  logic              ram_we;
  logic              ram_re;
  range_entry_t      wr_entry;
  range_entry_t      rd_entry;
  logic              overlap;

  assign sum        = {1'b0, base_frame_q} + {1'b0, span_q};
  assign last_frame = sum[FrameW] ? {FrameW{1'b1}} : sum[FrameW-1:0];
  assign first_pg   = FrameW'({page_q, {PageSubW{1'b0}}});
  assign final_pg   = FrameW'({page_q, {PageSubW{1'b1}}});

  assign ram_we   = (state_q == ST_LOAD_STORE);
  assign ram_re   = (state_q == ST_QUERY) && (issue_q < range_count_q);
  assign wr_entry = '{start_frame: base_frame_q, last_frame: last_frame, kind: type_q};

  mtrr_ram #(
    .Width ($bits(range_entry_t)),
    .Depth (MaxRanges)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (range_count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  assign overlap = pend_q && (first_pg <= rd_entry.last_frame) &&
                   (final_pg >= rd_entry.start_frame);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - TypeW - 3){1'b0}}, out_type_q, out_status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      base_frame_q  <= '0;
      mask_frame_q  <= '0;
      mask_valid_q  <= 1'b0;
      type_q        <= '0;
      page_q        <= '0;
      span_q        <= '0;
      issue_q       <= '0;
      range_count_q <= '0;
      pend_q        <= 1'b0;
      res_type_q    <= TypeUc;
      res_status_q  <= StStored;
      out_valid_q   <= 1'b0;
      out_status_q  <= StStored;
      out_type_q    <= TypeUc;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            base_frame_q <= s_axis_tdata[FrameLsb +: FrameW];
            mask_frame_q <= s_axis_tdata[64 + FrameLsb +: FrameW];
            mask_valid_q <= s_axis_tdata[64 + ValidBit];
            type_q       <= s_axis_tdata[TypeW-1:0];
            page_q       <= s_axis_tdata[128 +: PageW];
            issue_q      <= '0;
            pend_q       <= 1'b0;
            if (s_axis_tuser) begin
              res_status_q <= StQuery;
              if (s_axis_tdata[128 +: PageW] == '0) begin
                res_type_q <= TypeUc;
                state_q    <= ST_DONE;
              end else begin
                res_type_q <= TypeWb;
                state_q    <= ST_QUERY;
              end
            end else begin
              res_type_q <= TypeUc;
              state_q    <= ST_LOAD_CHECK;
            end
          end
        end
        ST_LOAD_CHECK: begin
          if (!mask_valid_q || (mask_frame_q == '0)) begin
            res_status_q <= StDisabled;
            state_q      <= ST_DONE;
          end else if (type_q == TypeWb) begin
            res_status_q <= StWbSkip;
            state_q      <= ST_DONE;
          end else if (range_count_q == CntW'(MaxRanges)) begin
            res_status_q <= StFull;
            state_q      <= ST_DONE;
          end else begin
            span_q  <= ~mask_frame_q & (mask_frame_q - FrameW'(1));
            state_q <= ST_LOAD_STORE;
          end
        end
        ST_LOAD_STORE: begin
          range_count_q <= range_count_q + CntW'(1);
          res_status_q  <= StStored;
          state_q       <= ST_DONE;
        end
        ST_QUERY: begin
          if (overlap && (rd_entry.kind == TypeUc)) begin
            res_type_q <= TypeUc;
            pend_q     <= 1'b0;
            state_q    <= ST_DONE;
          end else begin
            if (overlap) begin
              res_type_q <= rd_entry.kind;
            end
            if (ram_re) begin
              issue_q <= issue_q + CntW'(1);
              pend_q  <= 1'b1;
            end else begin
              pend_q <= 1'b0;
              if (!pend_q) begin
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_type_q   <= res_type_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MTRR_ASSERT(a_count_bound, range_count_q <= CntW'(MaxRanges), "range count overflow")
  `MTRR_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE, "no work started")
  `MTRR_ASSERT(a_count_hold, state_q != ST_LOAD_STORE |=> $stable(range_count_q), "count moved")
  `MTRR_ASSERT(a_read_bound, ram_re |-> issue_q < CntW'(MaxRanges), "table read beyond its depth")
  `MTRR_ASSERT_ALWAYS(a_status_code, m_axis_tvalid |-> out_status_q <= StQuery, "bad status")

endmodule
